>>> sv/gmf_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the gzip member framer.
package gmf_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 4;
    localparam int SHIFT_W  = 80;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START   = 2'd0,
        ACT_DATA    = 2'd1,
        ACT_PAYLOAD = 2'd2,
        ACT_FINISH  = 2'd3
    } t_action;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Header bytes, first byte in the least significant position.
    localparam logic [SHIFT_W-1:0] HDR_BYTES = 80'hFF_00_00_00_00_00_00_08_8B_1F;
    localparam logic [CNT_W-1:0]   HDR_LEN   = 4'd10;
    localparam logic [CNT_W-1:0]   TRL_LEN   = 4'd8;
    localparam logic [CNT_W-1:0]   PAY_LEN   = 4'd1;

    typedef struct packed {
        logic              clear;
        logic              fold;
        logic [BYTE_W-1:0] data;
    } t_state_cmd;

    typedef struct packed {
        logic               load;
        logic [CNT_W-1:0]   len;
        logic [SHIFT_W-1:0] bytes;
    } t_emit_load;

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/gmf_if.sv
// Valid/ready channel interfaces for the framer's input items and output bytes.
interface gmf_in_if import gmf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface gmf_out_if import gmf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> sv/gmf_state.sv
// Running CRC-32 and original-data byte count.
module gmf_state import gmf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_state_cmd  i_cmd,
    output logic [31:0] o_crc_final,
    output logic [31:0] o_count
);
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_count, n_count;

    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        if (i_cmd.clear) begin
            n_crc   = CRC_ONES;
            n_count = 32'd0;
        end else if (i_cmd.fold) begin
            n_crc   = crc_fold_byte(r_crc, i_cmd.data);
            n_count = r_count + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_ONES;
            r_count <= 32'd0;
        end else begin
            r_crc   <= n_crc;
            r_count <= n_count;
        end
    end

    assign o_crc_final = r_crc ^ CRC_ONES;
    assign o_count     = r_count;
endmodule

>>> sv/gmf_emit.sv
// Output byte shift register: loads a run of up to ten bytes and sends one per transaction.
module gmf_emit import gmf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_emit_load i_load,
    output logic       o_can_load,
    gmf_out_if.source  o_out
);
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_cnt;
    logic               take;

    assign take       = o_out.valid && o_out.ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load.load) begin
            r_cnt <= i_load.len;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Advance one byte per transaction; the head byte drives the port.
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_shift <= i_load.bytes;
        end else if (take) begin
            r_shift <= {{BYTE_W{1'b0}}, r_shift[SHIFT_W-1:BYTE_W]};
        end
    end

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_shift[BYTE_W-1:0];
    assign o_out.last     = (r_cnt == CNT_W'(1));
endmodule

>>> sv/gzip_member_framer_crc32.sv
// gzip member framer: header, payload pass-through and CRC-32/size trailer.
// An item passes stage A into the output shift register, which offers its first byte.
// Throughput: one item per cycle unless an output item waits in stage A; original-data
// items never stall, and an output item puts its 1, 8 or 10 bytes on the port.
// Reset (synchronous, active low): CRC all ones, count zero, all stages empty.
module gzip_member_framer_crc32 import gmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    gmf_in_if.sink   i_in,
    gmf_out_if.source o_out
);
    logic              r_a_valid;
    t_action           r_a_action;
    logic [BYTE_W-1:0] r_a_byte;
    logic              a_adv;
    logic              can_load;
    logic [31:0]       crc_final;
    logic [31:0]       count;
    t_state_cmd        state_cmd;
    t_emit_load        emit_load;

    assign a_adv      = r_a_valid && ((r_a_action == ACT_DATA) || can_load);
    assign i_in.ready = !r_a_valid || a_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_action <= t_action'(i_in.action);
            r_a_byte   <= i_in.data_byte;
        end
    end

    always_comb begin
        state_cmd.clear = a_adv && (r_a_action == ACT_START);
        state_cmd.fold  = a_adv && (r_a_action == ACT_DATA);
        state_cmd.data  = r_a_byte;
    end

    // Trailer reads the state before this cycle's update, which holds every earlier item.
    always_comb begin
        emit_load.load  = a_adv && (r_a_action != ACT_DATA);
        emit_load.len   = HDR_LEN;
        emit_load.bytes = HDR_BYTES;
        case (r_a_action)
            ACT_START: begin
                emit_load.len   = HDR_LEN;
                emit_load.bytes = HDR_BYTES;
            end
            ACT_PAYLOAD: begin
                emit_load.len   = PAY_LEN;
                emit_load.bytes = {{(SHIFT_W-BYTE_W){1'b0}}, r_a_byte};
            end
            ACT_FINISH: begin
                emit_load.len   = TRL_LEN;
                emit_load.bytes = {{(SHIFT_W-64){1'b0}}, count, crc_final};
            end
            default: begin
                emit_load.len   = '0;
                emit_load.bytes = '0;
            end
        endcase
    end

    gmf_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (state_cmd),
        .o_crc_final (crc_final),
        .o_count     (count)
    );

    gmf_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (emit_load),
        .o_can_load (can_load),
        .o_out      (o_out)
    );
endmodule

>>> verif/gmf_checker.sv
// Stream monitor for the gzip member framer: predicts every output byte and compares it.
module gmf_checker import gmf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gmf_in_if    in_ch,
    gmf_out_if   out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam int HEADER_LEN   = 10;
    localparam int TRAILER_WORD = 4;

    localparam logic [BYTE_W-1:0] MEMBER_HEADER [HEADER_LEN] = '{
        8'h1F, 8'h8B, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF
    };

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_stream_byte;

    t_stream_byte expected_stream[$];
    logic [31:0]  member_crc  = CRC_ONES;
    logic [31:0]  member_size = '0;
    int           mismatches  = 0;

    // Bit-serial form of the reflected CRC-32: one data bit per shift.
    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc,
                                                   input logic [BYTE_W-1:0] value);
        logic [31:0] acc;
        logic        feedback;
        acc = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            feedback = acc[0] ^ value[i];
            acc      = {1'b0, acc[31:1]};
            if (feedback) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic predict_stream(input t_action act, input logic [BYTE_W-1:0] value);
        logic [31:0] crc_out;
        crc_out = member_crc ^ CRC_ONES;
        case (act)
            ACT_START: begin
                member_crc  = CRC_ONES;
                member_size = '0;
                for (int k = 0; k < HEADER_LEN; k++) begin
                    expected_stream.push_back(
                        t_stream_byte'{MEMBER_HEADER[k], k == HEADER_LEN - 1});
                end
            end
            ACT_DATA: begin
                member_crc  = crc_after_byte(member_crc, value);
                member_size = member_size + 32'd1;
            end
            ACT_PAYLOAD: begin
                expected_stream.push_back(t_stream_byte'{value, 1'b1});
            end
            ACT_FINISH: begin
                // CRC first, then size, each least significant byte first
                for (int k = 0; k < TRAILER_WORD; k++) begin
                    expected_stream.push_back(t_stream_byte'{crc_out[8*k +: 8], 1'b0});
                end
                for (int k = 0; k < TRAILER_WORD; k++) begin
                    expected_stream.push_back(
                        t_stream_byte'{member_size[8*k +: 8], k == TRAILER_WORD - 1});
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            member_crc  = CRC_ONES;
            member_size = '0;
            mismatches  = 0;
            expected_stream.delete();
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_stream(t_action'(in_ch.action), in_ch.data_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_stream.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected output byte %02h last %0b", $time,
                                 out_ch.out_byte, out_ch.last);
                    end
                end else begin
                    want = expected_stream.pop_front();
                    if (want.value !== out_ch.out_byte || want.last !== out_ch.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: output byte %02h last %0b, expected %02h last %0b",
                                     $time, out_ch.out_byte, out_ch.last,
                                     want.value, want.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_stream.size();
    end

endmodule

>>> verif/gzip_member_framer_crc32_test.sv
// Top of the gzip member framer testbench: clock, reset, stimulus, back-pressure and verdict.
module gzip_member_framer_crc32_test;
    import gmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 460;
    localparam int MAX_IDLE       = 14;
    localparam int HOLD_OFF_AT    = 200;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   fail_count;
    int   pending;
    int   items_sent   = 0;
    int   quiet_cycles = 0;
    logic send_burst   = 1'b0;

    gmf_in_if  in_ch ();
    gmf_out_if out_ch ();

    gzip_member_framer_crc32 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gmf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one item after a random gap and hold it until the transaction completes.
    task automatic send_item(input t_action act, input logic [BYTE_W-1:0] value);
        int gap;
        if (items_sent % 32 == 0) begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.data_byte <= value;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    initial begin
        int steps;
        in_ch.valid     <= 1'b0;
        in_ch.action    <= ACT_START;
        in_ch.data_byte <= '0;
        i_rst_n         <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data ahead of any start folds into the reset state
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_FINISH, 8'h00);
        // empty member
        send_item(ACT_START, 8'h00);
        send_item(ACT_FINISH, 8'hFF);
        send_item(ACT_START, 8'hFF);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h55);
        send_item(ACT_DATA, 8'hAA);
        send_item(ACT_DATA, 8'h80);
        send_item(ACT_DATA, 8'h01);
        send_item(ACT_PAYLOAD, 8'h00);
        send_item(ACT_PAYLOAD, 8'hFF);
        send_item(ACT_PAYLOAD, 8'hA5);
        send_item(ACT_FINISH, 8'hAB);
        // repeated finish gives the same trailer, then more data extends it
        send_item(ACT_FINISH, 8'h5A);
        send_item(ACT_DATA, 8'h12);
        send_item(ACT_FINISH, 8'h00);
        send_item(ACT_START, 8'h3C);
        send_item(ACT_PAYLOAD, 8'h7F);
        send_item(ACT_FINISH, 8'hFF);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                send_item(ACT_START, BYTE_W'($urandom_range(0, 255)));
                steps = $urandom_range(0, 14);
                repeat (steps) begin
                    send_item($urandom_range(0, 1) ? ACT_DATA : ACT_PAYLOAD,
                              BYTE_W'($urandom_range(0, 255)));
                end
                send_item(ACT_FINISH, BYTE_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0) begin
                    send_item(ACT_FINISH, BYTE_W'($urandom_range(0, 255)));
                end
            end else begin
                send_item(t_action'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver: random stalls per byte, bursts of full rate, and one long hold-off.
    initial begin
        int   stall;
        int   taken;
        logic burst;
        taken = 0;
        burst = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 40 == 0) begin
                burst = ($urandom_range(0, 3) == 0);
            end
            if (taken == HOLD_OFF_AT) begin
                stall = HOLD_OFF_LEN;
            end else begin
                stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    // Abort when no transaction completes on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

>>> sim.f
sv/gmf_pkg.sv
sv/gmf_if.sv
sv/gmf_state.sv
sv/gmf_emit.sv
sv/gzip_member_framer_crc32.sv
verif/gmf_checker.sv
verif/gzip_member_framer_crc32_test.sv
